// File: hdl/bezier_polyline_evaluator_assert.svh
// Assertion macros shared by the bezier polyline evaluator modules.
`ifndef BEZIER_POLYLINE_EVALUATOR_ASSERT_SVH
`define BEZIER_POLYLINE_EVALUATOR_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define BPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/bpe_pkg.sv
// Shared types, constants and codes of the bezier polyline evaluator.
package bpe_pkg;

   localparam int MaxSegments = 16;
   localparam int SegBits     = 4;
   localparam int FracBits    = 16;
   localparam int PBits       = FracBits + 1;
   localparam logic [PBits-1:0] POne = PBits'(1) << FracBits;

   localparam logic [1:0] REQ_LOAD_POINT = 2'd0;
   localparam logic [1:0] REQ_LOAD_BREAK = 2'd1;
   localparam logic [1:0] REQ_EVAL_POS   = 2'd2;
   localparam logic [1:0] REQ_EVAL_DER   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SPAN  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_SEARCH, S_BASE, S_DIV, S_WEIGHT, S_MAC, S_DDIV, S_SAT, S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch request fields
      logic do_load;   // write stores
      logic srch_init;
      logic srch_step;
      logic base_get;
      logic div_init;
      logic div_step;
      logic wgt_step;
      logic mac_step;
      logic ddiv_init;
      logic ddiv_step;
      logic sat;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_bad;
      logic srch_done;
      logic span_bad;
      logic div_done;
      logic wgt_done;
      logic mac_done;
      logic ddiv_done;
      logic is_der;
      logic is_load;
   } stat_type;

endpackage

// File: hdl/bpe_ctrl.sv
// Controller state machine of the bezier polyline evaluator.
module bpe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bpe_pkg::stat_type  stat,
   output bpe_pkg::cmd_type   cmd
);

   bpe_pkg::state_type state_ff, state_in;

   // Advance state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpe_pkg::S_IDLE:   if (start) state_in = bpe_pkg::S_LOAD;
         bpe_pkg::S_LOAD:   state_in = stat.is_load ? bpe_pkg::S_DONE : bpe_pkg::S_SEARCH;
         bpe_pkg::S_SEARCH: if (stat.srch_done) state_in = bpe_pkg::S_BASE;
         bpe_pkg::S_BASE:   state_in = stat.span_bad ? bpe_pkg::S_DONE : bpe_pkg::S_DIV;
         bpe_pkg::S_DIV:    if (stat.div_done) state_in = bpe_pkg::S_WEIGHT;
         bpe_pkg::S_WEIGHT: if (stat.wgt_done) state_in = bpe_pkg::S_MAC;
         bpe_pkg::S_MAC: begin
            if (stat.mac_done) state_in = stat.is_der ? bpe_pkg::S_DDIV : bpe_pkg::S_SAT;
         end
         bpe_pkg::S_DDIV:   if (stat.ddiv_done) state_in = bpe_pkg::S_SAT;
         bpe_pkg::S_SAT:    state_in = bpe_pkg::S_DONE;
         bpe_pkg::S_DONE:   state_in = bpe_pkg::S_IDLE;
         default:           state_in = bpe_pkg::S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      busy = (state_ff != bpe_pkg::S_IDLE);
      case (state_ff)
         bpe_pkg::S_IDLE:   cmd.capture = start;
         bpe_pkg::S_LOAD: begin
            cmd.do_load = stat.is_load;
            cmd.srch_init = !stat.is_load;
         end
         bpe_pkg::S_SEARCH: cmd.srch_step = 1'b1;
         bpe_pkg::S_BASE: begin
            cmd.base_get = 1'b1;
            cmd.div_init = 1'b1;
         end
         bpe_pkg::S_DIV:    cmd.div_step = 1'b1;
         bpe_pkg::S_WEIGHT: cmd.wgt_step = 1'b1;
         bpe_pkg::S_MAC: begin
            cmd.mac_step = 1'b1;
            cmd.ddiv_init = stat.mac_done;
         end
         bpe_pkg::S_DDIV:   cmd.ddiv_step = 1'b1;
         bpe_pkg::S_SAT:    cmd.sat = 1'b1;
         bpe_pkg::S_DONE:   cmd.emit = 1'b1;
         default:           cmd = '0;
      endcase
   end

`include "bezier_polyline_evaluator_assert.svh"
   `BPE_ASSERT_NEXT(a_done_idle, clock, reset, state_ff == bpe_pkg::S_DONE, state_ff == bpe_pkg::S_IDLE)
   `BPE_ASSERT_IMP(a_emit_busy, clock, reset, cmd.emit, busy)
   `BPE_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)

endmodule

// File: hdl/bpe_datapath.sv
// Datapath of the bezier polyline evaluator: stores, search, dividers, multiply-accumulate.
module bpe_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bpe_pkg::cmd_type    cmd,
   output bpe_pkg::stat_type   stat,
   input  logic [4:0]          seg_count,
   input  logic [1:0]          req_type,
   input  logic [3:0]          seg_index,
   input  logic [1:0]          point_index,
   input  logic signed [31:0]  coord_x,
   input  logic signed [31:0]  coord_y,
   input  logic signed [31:0]  coord_z,
   input  logic signed [18:0]  param_value,
   output logic [1:0]          status,
   output logic [3:0]          found_segment,
   output logic signed [47:0]  out_x,
   output logic signed [47:0]  out_y,
   output logic signed [47:0]  out_z
);

   localparam int F = bpe_pkg::FracBits;
   localparam int PB = bpe_pkg::PBits;
   localparam int AccW = 56;

   // Request capture.
   logic [1:0] type_ff;
   logic [3:0] seg_ff;
   logic [1:0] pt_ff;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [PB-1:0] t_ff;
   logic [4:0] n_ff;
   logic [PB-1:0] tclamp;

   always_comb begin
      if (param_value[18]) tclamp = '0;
      else if (param_value > 19'sd65536) tclamp = bpe_pkg::POne;
      else tclamp = param_value[PB-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         seg_ff <= seg_index;
         pt_ff <= point_index;
         cx_ff <= coord_x;
         cy_ff <= coord_y;
         cz_ff <= coord_z;
         t_ff <= tclamp;
         if (seg_count == 5'd0) n_ff <= 5'd1;
         else if (seg_count > 5'(bpe_pkg::MaxSegments)) n_ff <= 5'(bpe_pkg::MaxSegments);
         else n_ff <= seg_count;
      end
   end

   logic is_load;
   logic load_bad;
   assign is_load = (type_ff == bpe_pkg::REQ_LOAD_POINT) || (type_ff == bpe_pkg::REQ_LOAD_BREAK);
   assign load_bad = ({1'b0, seg_ff} >= n_ff);

   // Breakpoint store: small, held in flip-flops.
   logic [PB-1:0] bp_ff [bpe_pkg::MaxSegments];
   // Control point store: one 96-bit row per point.
   logic [95:0] cp_mem [bpe_pkg::MaxSegments*4];
   logic [95:0] cp_rd_ff;
   logic [5:0] cp_addr;

   // Search state.
   logic [3:0] idx_ff;
   logic srch_done_ff;
   logic [1:0] k_ff;   // control point counter for the accumulate

   always_ff @(posedge clock) begin
      if (cmd.do_load && !load_bad) begin
         if (type_ff == bpe_pkg::REQ_LOAD_POINT) cp_mem[{seg_ff, pt_ff}] <= {cx_ff, cy_ff, cz_ff};
         else bp_ff[seg_ff] <= t_ff;
      end
   end

   // Walk breakpoints one per cycle.
   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         idx_ff <= '0;
         srch_done_ff <= 1'b0;
      end else if (cmd.srch_step && !srch_done_ff) begin
         if (({1'b0, idx_ff} + 5'd1 < n_ff) && (t_ff > bp_ff[idx_ff])) idx_ff <= idx_ff + 4'd1;
         else srch_done_ff <= 1'b1;
      end
   end

   // Span and base.
   logic signed [PB:0] span_w;
   logic [PB-1:0] span_ff;
   logic span_bad_ff;
   logic [PB-1:0] base_w;
   assign base_w = (idx_ff == 4'd0) ? '0 : bp_ff[idx_ff - 4'd1];
   assign span_w = $signed({1'b0, bp_ff[idx_ff]}) - $signed({1'b0, base_w});

   always_ff @(posedge clock) begin
      if (cmd.base_get) begin
         span_ff <= span_w[PB-1:0];
         span_bad_ff <= (span_w <= 0);
      end
   end

   // Restoring divider for u = (num << F) / span, one bit a cycle.
   localparam int DW = PB + F;
   logic [DW-1:0] dq_ff;
   logic [PB:0] drem_ff;
   logic [5:0] dcnt_ff;
   logic [PB:0] dtrial;
   logic [PB-1:0] num_w;
   assign num_w = (t_ff > base_w) ? t_ff - base_w : '0;
   assign dtrial = {drem_ff[PB-1:0], dq_ff[DW-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dq_ff <= {num_w, {F{1'b0}}};
         drem_ff <= '0;
         dcnt_ff <= 6'(DW);
      end else if (cmd.div_step && dcnt_ff != 6'd0) begin
         dcnt_ff <= dcnt_ff - 6'd1;
         if (dtrial >= {1'b0, span_ff}) begin
            drem_ff <= dtrial - {1'b0, span_ff};
            dq_ff <= {dq_ff[DW-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial;
            dq_ff <= {dq_ff[DW-2:0], 1'b0};
         end
      end
   end

   logic [PB-1:0] u_w, w_w;
   assign u_w = (dq_ff > DW'(bpe_pkg::POne)) ? bpe_pkg::POne : dq_ff[PB-1:0];
   assign w_w = bpe_pkg::POne - u_w;

   // Weights through a shared narrow multiplier, one product a cycle.
   logic [PB-1:0] uu_ff, ww_ff, uw_ff, j0_ff, j1_ff, j2_ff, j3_ff;
   logic [2:0] wcnt_ff;
   logic [PB-1:0] ma, mb;
   logic [2*PB-1:0] mp;
   logic [PB-1:0] qm;
   always_comb begin
      case (wcnt_ff)
         3'd0: begin ma = u_w; mb = u_w; end
         3'd1: begin ma = w_w; mb = w_w; end
         3'd2: begin ma = u_w; mb = w_w; end
         3'd3: begin ma = ww_ff; mb = w_w; end
         3'd4: begin ma = ww_ff; mb = u_w; end
         3'd5: begin ma = uu_ff; mb = w_w; end
         3'd6: begin ma = uu_ff; mb = u_w; end
         default: begin ma = '0; mb = '0; end
      endcase
      mp = ma * mb;
   end
   logic [2*PB-1:0] mp_r;
   assign mp_r = mp + (2*PB)'(1 << (F-1));
   assign qm = mp_r[F+PB-1:F];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         wcnt_ff <= '0;
      end else if (cmd.wgt_step && wcnt_ff != 3'd7) begin
         wcnt_ff <= wcnt_ff + 3'd1;
         case (wcnt_ff)
            3'd0: uu_ff <= qm;
            3'd1: ww_ff <= qm;
            3'd2: uw_ff <= qm;
            3'd3: j0_ff <= qm;
            3'd4: j1_ff <= qm;
            3'd5: j2_ff <= qm;
            3'd6: j3_ff <= qm;
            default: j3_ff <= qm;
         endcase
      end
   end

   // Signed coefficient per control point.
   logic signed [PB+3:0] coef;
   logic is_der;
   assign is_der = (type_ff == bpe_pkg::REQ_EVAL_DER);
   always_comb begin
      if (!is_der) begin
         case (k_ff)
            2'd0: coef = $signed({4'b0, j0_ff});
            2'd1: coef = (PB+4)'(3 * $signed({4'b0, j1_ff}));
            2'd2: coef = (PB+4)'(3 * $signed({4'b0, j2_ff}));
            default: coef = $signed({4'b0, j3_ff});
         endcase
      end else begin
         case (k_ff)
            2'd0: coef = (PB+4)'(-3 * $signed({4'b0, ww_ff}));
            2'd1: coef = (PB+4)'(3 * ($signed({4'b0, ww_ff}) - 2 * $signed({4'b0, uw_ff})));
            2'd2: coef = (PB+4)'(3 * (2 * $signed({4'b0, uw_ff}) - $signed({4'b0, uu_ff})));
            default: coef = (PB+4)'(3 * $signed({4'b0, uu_ff}));
         endcase
      end
   end

   // Accumulate each control point in the cycle after its row read.
   logic signed [AccW-1:0] acc_ff [3];
   logic mac_phase_ff;
   logic mac_done_ff;
   assign cp_addr = {idx_ff, k_ff};
   always_ff @(posedge clock) begin
      cp_rd_ff <= cp_mem[cp_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         k_ff <= '0;
         mac_phase_ff <= 1'b0;
         mac_done_ff <= 1'b0;
         for (int c = 0; c < 3; c++) acc_ff[c] <= '0;
      end else if (cmd.mac_step && !mac_done_ff) begin
         if (!mac_phase_ff) begin
            mac_phase_ff <= 1'b1;
         end else begin
            acc_ff[0] <= acc_ff[0] + AccW'($signed(cp_rd_ff[95:64]) * coef);
            acc_ff[1] <= acc_ff[1] + AccW'($signed(cp_rd_ff[63:32]) * coef);
            acc_ff[2] <= acc_ff[2] + AccW'($signed(cp_rd_ff[31:0]) * coef);
            mac_phase_ff <= 1'b0;
            k_ff <= k_ff + 2'd1;
            if (k_ff == 2'd3) mac_done_ff <= 1'b1;
         end
      end
   end

   // Derivative divide: |acc| + span/2 over span, bit-serial on all three axes.
   localparam int QW = AccW;
   logic [QW-1:0] qq_ff [3];
   logic [PB:0] qr_ff [3];
   logic [2:0] neg_ff;
   logic [6:0] qcnt_ff;
   always_ff @(posedge clock) begin
      if (cmd.ddiv_init) begin
         qcnt_ff <= 7'(QW);
         for (int c = 0; c < 3; c++) begin
            neg_ff[c] <= acc_ff[c][AccW-1];
            qq_ff[c] <= (acc_ff[c][AccW-1] ? QW'(-acc_ff[c]) : QW'(acc_ff[c]))
                        + QW'(span_ff >> 1);
            qr_ff[c] <= '0;
         end
      end else if (cmd.ddiv_step && qcnt_ff != 7'd0) begin
         qcnt_ff <= qcnt_ff - 7'd1;
         for (int c = 0; c < 3; c++) begin
            if ({qr_ff[c][PB-1:0], qq_ff[c][QW-1]} >= {1'b0, span_ff}) begin
               qr_ff[c] <= {qr_ff[c][PB-1:0], qq_ff[c][QW-1]} - {1'b0, span_ff};
               qq_ff[c] <= {qq_ff[c][QW-2:0], 1'b1};
            end else begin
               qr_ff[c] <= {qr_ff[c][PB-1:0], qq_ff[c][QW-1]};
               qq_ff[c] <= {qq_ff[c][QW-2:0], 1'b0};
            end
         end
      end
   end

   // Round or take quotient, then saturate.
   logic signed [47:0] res_ff [3];
   logic signed [AccW:0] pre [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (is_der) pre[c] = neg_ff[c] ? -$signed({1'b0, qq_ff[c]}) : $signed({1'b0, qq_ff[c]});
         else pre[c] = (AccW+1)'((acc_ff[c] + AccW'(1 << (F-1))) >>> F);
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.sat) begin
         for (int c = 0; c < 3; c++) begin
            if (pre[c] > (AccW+1)'(48'sh7FFF_FFFF_FFFF)) res_ff[c] <= 48'sh7FFF_FFFF_FFFF;
            else if (pre[c] < -(AccW+1)'(49'sh0_8000_0000_0000)) res_ff[c] <= 48'sh8000_0000_0000;
            else res_ff[c] <= pre[c][47:0];
         end
      end
   end

   // Form result.
   always_comb begin
      status = bpe_pkg::ST_OK;
      found_segment = idx_ff;
      out_x = res_ff[0];
      out_y = res_ff[1];
      out_z = res_ff[2];
      if (is_load) begin
         found_segment = '0;
         out_x = '0; out_y = '0; out_z = '0;
         if (load_bad) status = bpe_pkg::ST_RANGE;
      end else if (span_bad_ff) begin
         status = bpe_pkg::ST_SPAN;
         out_x = '0; out_y = '0; out_z = '0;
      end
   end

   assign stat.load_bad = load_bad;
   assign stat.srch_done = srch_done_ff;
   assign stat.span_bad = (span_w <= 0);
   assign stat.div_done = (dcnt_ff == 6'd0);
   assign stat.wgt_done = (wcnt_ff == 3'd7);
   assign stat.mac_done = mac_done_ff;
   assign stat.ddiv_done = (qcnt_ff == 7'd0);
   assign stat.is_der = is_der;
   assign stat.is_load = is_load;

`include "bezier_polyline_evaluator_assert.svh"
   `BPE_ASSERT_IMP(a_u_range, clock, reset, cmd.wgt_step, u_w <= bpe_pkg::POne)
   `BPE_ASSERT_IMP(a_span_pos, clock, reset, cmd.div_step, span_ff != '0)
   `BPE_ASSERT_IMP(a_idx_range, clock, reset, cmd.srch_step, {1'b0, idx_ff} < n_ff)

endmodule

// File: hdl/bezier_polyline_evaluator.sv
// One item at a time, the next start beat taken in the cycle after the result beat; the
// breakpoint walk, a 33-step divider for the local parameter, seven weight products, four
// accumulate steps that each read a row and then add it, and a 56-step divider for
// derivatives make up the work of an evaluation; a load and an empty span skip most of it.
// Reset (synchronous, high) clears the controller and sets segments_in_use to 1; no stall.
module bezier_polyline_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [3:0]         req_seg_index,
   input  logic [1:0]         req_point_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic signed [18:0] req_param_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_found_segment,
   output logic signed [47:0] rsp_out_x,
   output logic signed [47:0] rsp_out_y,
   output logic signed [47:0] rsp_out_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_segments_in_use
);

   bpe_pkg::cmd_type  cmd;
   bpe_pkg::stat_type stat;
   logic [4:0] segs_ff;

   // Hold the segment count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         segs_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         segs_ff <= csr_segments_in_use;
      end
   end
   assign csr_ready = 1'b1;
   assign rsp_valid = cmd.emit;

   bpe_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .stat (stat), .cmd (cmd)
   );

   bpe_datapath u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .stat (stat),
      .seg_count (segs_ff), .req_type (req_type), .seg_index (req_seg_index),
      .point_index (req_point_index), .coord_x (req_coord_x), .coord_y (req_coord_y),
      .coord_z (req_coord_z), .param_value (req_param_value),
      .status (rsp_status), .found_segment (rsp_found_segment),
      .out_x (rsp_out_x), .out_y (rsp_out_y), .out_z (rsp_out_z)
   );

endmodule

// File: test/tb.sv
// Self-checking testbench for the bezier polyline evaluator.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {WORK_REQ, WORK_CSR, WORK_DRAIN} work_kind_type;

   typedef struct {
      work_kind_type      kind;
      int                 idle_pct;
      logic [1:0]         op;
      logic [3:0]         seg;
      logic [1:0]         pt;
      logic signed [31:0] x, y, z;
      logic signed [18:0] param;
      logic [4:0]         seg_count;
   } work_type;

   typedef struct {
      logic [1:0]         status;
      logic [3:0]         seg;
      logic signed [47:0] x, y, z;
   } curve_result_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_type = bpe_pkg::REQ_LOAD_POINT;
   logic [3:0]         req_seg_index = '0;
   logic [1:0]         req_point_index = '0;
   logic signed [31:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic signed [18:0] req_param_value = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_found_segment;
   logic signed [47:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [4:0]         csr_segments_in_use = 5'd1;

   bezier_polyline_evaluator u_dut (.*);

   initial forever #2 clock = ~clock;

   // Shadow of the curve: control points, breakpoints and segment count.
   longint  ctrl_pts [bpe_pkg::MaxSegments][4][3];
   longint  breakpts [bpe_pkg::MaxSegments];
   logic [4:0] seg_count_reg = 5'd1;

   work_type         work_q [$];
   curve_result_type curve_q [$];
   work_type         cur;
   bit               holding = 0;
   int               n_req = 0, n_csr = 0, n_rsp = 0, n_err = 0, n_range = 0, n_span = 0;
   int               idle_pct = 29;
   bit               failed = 0;
   int               quiet_cycles = 0;

   function automatic longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > (longint'(1) << bpe_pkg::FracBits)) return longint'(1) << bpe_pkg::FracBits;
      return v;
   endfunction

   function automatic longint qprod(longint a, longint b);
      return (a * b + (longint'(1) << (bpe_pkg::FracBits - 1))) >>> bpe_pkg::FracBits;
   endfunction

   function automatic longint sat48(longint v);
      if (v > (longint'(1) << 47) - 1) return (longint'(1) << 47) - 1;
      if (v < -(longint'(1) << 47)) return -(longint'(1) << 47);
      return v;
   endfunction

   // Apply one request to the shadow curve and return the answer it must give.
   function automatic curve_result_type curve_predict(work_type r);
      curve_result_type res;
      int      n, s;
      longint  t, base, span, u, w, ww, uu, uw, acc, mag, q;
      longint  j [4];
      longint  cv [3];
      res = '{bpe_pkg::ST_OK, 4'd0, 48'sd0, 48'sd0, 48'sd0};
      n = (seg_count_reg == 0) ? 1
        : (seg_count_reg > bpe_pkg::MaxSegments) ? bpe_pkg::MaxSegments
        : int'(seg_count_reg);
      if (r.op == bpe_pkg::REQ_LOAD_POINT || r.op == bpe_pkg::REQ_LOAD_BREAK) begin
         if (int'(r.seg) >= n) begin
            res.status = bpe_pkg::ST_RANGE;
         end else if (r.op == bpe_pkg::REQ_LOAD_POINT) begin
            ctrl_pts[r.seg][r.pt][0] = longint'(r.x);
            ctrl_pts[r.seg][r.pt][1] = longint'(r.y);
            ctrl_pts[r.seg][r.pt][2] = longint'(r.z);
         end else begin
            breakpts[r.seg] = clamp_unit(longint'(r.param));
         end
         return res;
      end
      t = clamp_unit(longint'(r.param));
      s = 0;
      while (s + 1 < n && t > breakpts[s]) s++;
      base = (s == 0) ? 0 : breakpts[s-1];
      span = breakpts[s] - base;
      res.seg = 4'(s);
      if (span <= 0) begin
         res.status = bpe_pkg::ST_SPAN;
         return res;
      end
      u = ((t - base) << bpe_pkg::FracBits) / span;
      if (u > (longint'(1) << bpe_pkg::FracBits)) u = longint'(1) << bpe_pkg::FracBits;
      w  = (longint'(1) << bpe_pkg::FracBits) - u;
      ww = qprod(w, w);
      uu = qprod(u, u);
      uw = qprod(u, w);
      if (r.op == bpe_pkg::REQ_EVAL_POS) begin
         j[0] = qprod(ww, w);
         j[1] = 3 * qprod(ww, u);
         j[2] = 3 * qprod(uu, w);
         j[3] = qprod(uu, u);
      end else begin
         j[0] = -ww;
         j[1] = ww - 2 * uw;
         j[2] = 2 * uw - uu;
         j[3] = uu;
      end
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) acc += ctrl_pts[s][k][c] * j[k];
         if (r.op == bpe_pkg::REQ_EVAL_POS) begin
            cv[c] = sat48((acc + (longint'(1) << (bpe_pkg::FracBits - 1)))
                          >>> bpe_pkg::FracBits);
         end else begin
            acc = 3 * acc;
            mag = (acc < 0) ? -acc : acc;
            q = (mag + span / 2) / span;
            cv[c] = sat48((acc < 0) ? -q : q);
         end
      end
      res.x = 48'(cv[0]);
      res.y = 48'(cv[1]);
      res.z = 48'(cv[2]);
      return res;
   endfunction

   // Drive request and register beats from the work queue.
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         holding   = 0;
      end else begin
         if (start && !busy) begin
            curve_q.push_back(curve_predict(cur));
            n_req++;
            holding = 0;
         end
         if (csr_valid && csr_ready) begin
            seg_count_reg = cur.seg_count;
            n_csr++;
            holding = 0;
         end
         if (!holding && work_q.size() > 0) begin
            case (work_q[0].kind)
               WORK_DRAIN: begin
                  if (curve_q.size() == 0 && !busy) void'(work_q.pop_front());
               end
               WORK_CSR: begin
                  if (curve_q.size() == 0 && !busy) begin
                     cur = work_q.pop_front();
                     holding = 1;
                  end
               end
               default: begin
                  if ($urandom_range(99) >= work_q[0].idle_pct) begin
                     cur = work_q.pop_front();
                     holding = 1;
                  end
               end
            endcase
         end
         start     <= holding && cur.kind == WORK_REQ;
         csr_valid <= holding && cur.kind == WORK_CSR;
         if (holding) begin
            req_type            <= cur.op;
            req_seg_index       <= cur.seg;
            req_point_index     <= cur.pt;
            req_coord_x         <= cur.x;
            req_coord_y         <= cur.y;
            req_coord_z         <= cur.z;
            req_param_value     <= cur.param;
            csr_segments_in_use <= cur.seg_count;
         end
      end
   end

   // Check each result beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (curve_q.size() == 0) begin
            $error("unexpected result beat");
            failed = 1;
         end else begin
            automatic curve_result_type e = curve_q.pop_front();
            if (rsp_status != e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               failed = 1;
            end
            if (rsp_found_segment != e.seg) begin
               $error("found_segment: expected %0d, got %0d", e.seg, rsp_found_segment);
               failed = 1;
            end
            if (rsp_out_x != e.x) begin
               $error("out_x: expected %0d, got %0d", e.x, rsp_out_x);
               failed = 1;
            end
            if (rsp_out_y != e.y) begin
               $error("out_y: expected %0d, got %0d", e.y, rsp_out_y);
               failed = 1;
            end
            if (rsp_out_z != e.z) begin
               $error("out_z: expected %0d, got %0d", e.z, rsp_out_z);
               failed = 1;
            end
            if (e.status == bpe_pkg::ST_RANGE) n_range++;
            if (e.status == bpe_pkg::ST_SPAN) n_span++;
         end
      end
   end

   // Stop a hung run: count cycles without any beat.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 4000) begin
         $display("bezier_polyline_evaluator verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(logic [1:0] op, logic [3:0] seg, logic [1:0] pt,
                           logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [18:0] param);
      work_type wk;
      wk = '{WORK_REQ, idle_pct, op, seg, pt, x, y, z, param, 5'd0};
      work_q.push_back(wk);
   endtask

   task automatic push_csr(logic [4:0] count);
      work_type wk;
      wk = '{WORK_CSR, 0, bpe_pkg::REQ_LOAD_POINT, 4'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0,
             19'sd0, count};
      work_q.push_back(wk);
   endtask

   task automatic push_drain();
      work_type wk;
      wk = '{WORK_DRAIN, 0, bpe_pkg::REQ_LOAD_POINT, 4'd0, 2'd0, 32'sd0, 32'sd0, 32'sd0,
             19'sd0, 5'd0};
      work_q.push_back(wk);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $signed($urandom_range(0, 200000)) - 100000;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   function automatic logic signed [18:0] rand_param();
      case ($urandom_range(7))
         0: return -19'sd65536;
         1: return 19'sd131072;
         2: return 19'sd0;
         3: return 19'sd65536;
         default: return 19'($signed($urandom_range(0, 196608)) - 65536);
      endcase
   endfunction

   // Rewrite breakpoints 0..15 as a nondecreasing ramp, zero steps now and then.
   task automatic push_ramp(int max_step);
      int acc;
      acc = 0;
      for (int s = 0; s < bpe_pkg::MaxSegments; s++) begin
         acc += ($urandom_range(9) == 0) ? 0 : $urandom_range(1, max_step);
         push_req(bpe_pkg::REQ_LOAD_BREAK, 4'(s), 2'd0, 0, 0, 0,
                  (s == bpe_pkg::MaxSegments - 1) ? 19'sd65536 : 19'(acc));
      end
   endtask

   task automatic push_random(int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 2) push_ramp($urandom_range(1) ? 8192 : 600);
         else if (r < 42) push_req(bpe_pkg::REQ_EVAL_POS, 4'($urandom()), 2'($urandom()),
                                   rand_coord(), rand_coord(), rand_coord(), rand_param());
         else if (r < 80) push_req(bpe_pkg::REQ_EVAL_DER, 4'($urandom()), 2'($urandom()),
                                   rand_coord(), rand_coord(), rand_coord(), rand_param());
         else if (r < 94) push_req(bpe_pkg::REQ_LOAD_POINT, 4'($urandom()), 2'($urandom()),
                                   rand_coord(), rand_coord(), rand_coord(), rand_param());
         else push_req(bpe_pkg::REQ_LOAD_BREAK, 4'($urandom()), 2'($urandom()),
                       rand_coord(), rand_coord(), rand_coord(), rand_param());
      end
   endtask

   // Build the stimulus, release reset, wait for the curve to drain, report.
   initial begin
      // Fill every store entry first so nothing unwritten is ever read.
      push_csr(5'd16);
      for (int s = 0; s < bpe_pkg::MaxSegments; s++)
         for (int p = 0; p < 4; p++)
            push_req(bpe_pkg::REQ_LOAD_POINT, 4'(s), 2'(p), rand_coord(), rand_coord(),
                     rand_coord(), 19'sd0);
      for (int s = 0; s < bpe_pkg::MaxSegments; s++)
         push_req(bpe_pkg::REQ_LOAD_BREAK, 4'(s), 2'd0, 0, 0, 0, 19'((s + 1) * 4096));

      // Directed: parameter ends, clamps, breakpoint clamps, empty span, range.
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, -19'sd65536);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd0);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd65536);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd131072);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd0);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd65536);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd30000);
      push_req(bpe_pkg::REQ_LOAD_POINT, 4'd0, 2'd0, 32'sh7fffffff, 32'sh80000000,
               32'sh7fffffff, 19'sd0);
      push_req(bpe_pkg::REQ_LOAD_POINT, 4'd0, 2'd1, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 19'sd0);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd0, 2'd0, 0, 0, 0, 19'sd1);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd0);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd1);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd1, 2'd0, 0, 0, 0, 19'sd1);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd1);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd1);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd15, 2'd0, 0, 0, 0, 19'sd131072);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd14, 2'd0, 0, 0, 0, -19'sd65536);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd65536);
      push_drain();
      push_csr(5'd1);
      push_req(bpe_pkg::REQ_LOAD_POINT, 4'd3, 2'd3, 1, 2, 3, 19'sd0);
      push_req(bpe_pkg::REQ_EVAL_POS, 4'd0, 2'd0, 0, 0, 0, 19'sd40000);
      push_csr(5'd31);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd15, 2'd0, 0, 0, 0, 19'sd65536);
      push_csr(5'd0);
      push_req(bpe_pkg::REQ_LOAD_BREAK, 4'd1, 2'd0, 0, 0, 0, 19'sd100);
      push_req(bpe_pkg::REQ_EVAL_DER, 4'd0, 2'd0, 0, 0, 0, 19'sd131072);

      // Random phases: sender idles rarely, often, then never.
      push_csr(5'd16);
      push_ramp(4096);
      push_random(160);
      push_csr(5'($urandom_range(1, 16)));
      push_random(160);
      push_drain();
      idle_pct = 83;
      push_csr(5'd31);
      push_ramp(8192);
      push_random(160);
      push_csr(5'($urandom_range(2, 15)));
      push_random(160);
      idle_pct = 0;
      push_csr(5'd16);
      push_ramp(600);
      push_random(160);
      push_csr(5'd0);
      push_random(60);
      push_csr(5'($urandom_range(0, 31)));
      push_random(140);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (work_q.size() != 0 || holding || curve_q.size() != 0);
      repeat (150) @(posedge clock);

      if (curve_q.size() != 0) failed = 1;
      $display("Covered %0d requests, %0d results (%0d range, %0d empty span), %0d csr writes",
               n_req, n_rsp, n_range, n_span, n_csr);
      if (!failed) begin
         $display("bezier_polyline_evaluator verification clean");
      end else begin
         $display("bezier_polyline_evaluator verification failed");
      end
      $finish;
   end

endmodule
